/* rtl/abg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abg_pkg: shared definitions of the ADC averaging battery gauge
// Field widths, arithmetic constants, register indexes, state types and the
// structs that pass between the gauge's modules.
// ----------------------------------------------------------------------------
package abg_pkg;

  // Field widths.
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 18;
  localparam int CNT_W    = 7;
  localparam int RATIO_W  = 17;
  localparam int MV_W     = 16;
  localparam int PCT_W    = 7;
  localparam int CFG_W    = RATIO_W;
  localparam int CFG_IDX_W = 2;

  // Gauge constants.
  localparam int MAX_SAMPLES    = 64;
  localparam int ADC_FULL_SCALE = 4095;
  localparam int MV_SCALE       = 3300;
  localparam int PCT_SCALE      = 100;

  // Largest group size: MAX_SAMPLES, capped to what the count register can express.
  localparam int CNT_CAP = (MAX_SAMPLES > (2**CNT_W - 1)) ? (2**CNT_W - 1) : MAX_SAMPLES;

  // Shared divider geometry. A quotient that does not fit in QUOT_W bits is saturated.
  localparam int QUOT_W  = 16;
  localparam int FS_W    = $clog2(ADC_FULL_SCALE + 1);
  localparam int SCALE_W = $clog2(MV_SCALE + 1);
  localparam int PROD_W  = SAMPLE_W + SCALE_W;
  localparam int NUM_W   = PROD_W + QUOT_W;
  localparam int DEN_W   = FS_W + RATIO_W;
  localparam int REM_W   = (DEN_W > PROD_W) ? DEN_W : PROD_W;
  localparam int STEP_W  = $clog2(QUOT_W);
  localparam int PPROD_W = MV_W + $clog2(PCT_SCALE + 1);

  localparam logic [SAMPLE_W-1:0] AVG_MAX = {SAMPLE_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT = 2'd0,
    REG_DIVIDER      = 2'd1,
    REG_EMPTY_MV     = 2'd2,
    REG_FULL_MV      = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_RUN,
    ST_MV_START,
    ST_MV_RUN,
    ST_PCT_START,
    ST_PCT_RUN,
    ST_EMIT
  } gauge_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef struct packed {
    logic             close;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] n;
  } acc_status_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/abg_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abg_accum: sample accumulator
// Keeps the running sum and count of the current group and flags the word
// that closes it.
// ----------------------------------------------------------------------------
module abg_accum import abg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                sample_ok_i,
  input  logic [CNT_W-1:0]    sample_count_i,
  output acc_status_t         status_o
);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] taken_q, taken_d;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] taken_new;
  logic [CNT_W-1:0] n;

  always_comb begin
    if (sample_count_i == '0) begin
      n = CNT_W'(1);
    end else if (sample_count_i > CNT_W'(CNT_CAP)) begin
      n = CNT_W'(CNT_CAP);
    end else begin
      n = sample_count_i;
    end
  end

  assign sum_new   = sum_q + SUM_W'(sample_i);
  assign taken_new = taken_q + CNT_W'(1);

  assign status_o.close = sample_ok_i && (taken_new >= n);
  assign status_o.sum   = sum_new;
  assign status_o.n     = n;

  always_comb begin
    sum_d   = sum_q;
    taken_d = taken_q;
    if (accept_i) begin
      if (!sample_ok_i || status_o.close) begin
        sum_d   = '0;
        taken_d = '0;
      end else begin
        sum_d   = sum_new;
        taken_d = taken_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      taken_q <= '0;
    end else begin
      sum_q   <= sum_d;
      taken_q <= taken_d;
    end
  end

endmodule

/* rtl/abg_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abg_div: bit-serial restoring divider
// Produces one quotient bit per cycle. A quotient that does not fit in
// QUOT_W bits, or a zero divisor, gives the all-ones quotient.
// ----------------------------------------------------------------------------
module abg_div import abg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output div_rsp_t         rsp_o
);

  div_state_e state_q, state_d;

  logic [REM_W-1:0]  rem_q;
  logic [QUOT_W-1:0] lo_q;
  logic [DEN_W-1:0]  den_q;
  logic [QUOT_W-1:0] quot_q;
  logic [STEP_W-1:0] step_q;

  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             fits;
  logic [REM_W-1:0] rem_next;
  logic             sat;
  logic             last_step;

  // The high part of the dividend is already the first partial remainder;
  // if it is not below the divisor the quotient overflows.
  assign sat       = rem_q >= REM_W'(den_q);
  assign trial     = {rem_q, lo_q[QUOT_W-1]};
  assign diff      = trial - (REM_W + 1)'(den_q);
  assign fits      = trial >= (REM_W + 1)'(den_q);
  assign rem_next  = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
  assign last_step = step_q == STEP_W'(QUOT_W - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE:  if (start_i) state_d = DIV_CHECK;
      DIV_CHECK: state_d = sat ? DIV_DONE : DIV_RUN;
      DIV_RUN:   if (last_step) state_d = DIV_DONE;
      DIV_DONE:  state_d = DIV_IDLE;
      default:   state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = state_q == DIV_DONE;
    rsp_o.quot = quot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_RUN) begin
        step_q <= step_q + STEP_W'(1);
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      rem_q <= REM_W'(num_i[NUM_W-1:QUOT_W]);
      lo_q  <= num_i[QUOT_W-1:0];
      den_q <= den_i;
    end else if (state_q == DIV_CHECK && sat) begin
      quot_q <= '1;
    end else if (state_q == DIV_RUN) begin
      rem_q  <= rem_next;
      lo_q   <= {lo_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], fits};
    end
  end

endmodule

/* rtl/adc_average_battery_gauge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_average_battery_gauge: ADC averaging battery gauge
// Averages groups of ADC samples and reports the mean raw value, the supply
// voltage in millivolts and a battery charge percent for each group.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Word
//  -------  ---------  ------------------------  ---------------------------
//  in       sink       in_valid_i / in_stall_o   sample_i, sample_ok_i
//  out      source     out_valid_o / out_stall_i average_raw_o, supply_mv_o,
//                                                charge_percent_o, read_error_o
//  cfg      sink       cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// A sample that does not close its group is taken without a stall, and the next
// word can follow at once. A closing sample starts three divisions in turn on
// one bit-serial divider (mean, millivolts, percent), with a setup state
// before each of the last two. The percent division is skipped when the
// voltage lies outside the band. The input stays stalled until the result
// word is loaded into the output register. A failed sample is answered with
// an error word.
// Reset clears the group and loads the register defaults.
// The output register holds a finished word while out_stall_i is high, and
// the input keeps taking samples meanwhile; only a new result waits for it.
//
module adc_average_battery_gauge import abg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Sample input.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 sample_ok_i,
  // Result output.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SAMPLE_W-1:0]  average_raw_o,
  output logic [MV_W-1:0]      supply_mv_o,
  output logic [PCT_W-1:0]     charge_percent_o,
  output logic                 read_error_o,
  // Configuration writes.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Configuration registers.
  logic [CNT_W-1:0]   sample_count_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [MV_W-1:0]    empty_mv_q;
  logic [MV_W-1:0]    full_mv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= CNT_W'(8);
      ratio_q        <= RATIO_W'(32768);
      empty_mv_q     <= MV_W'(3000);
      full_mv_q      <= MV_W'(4200);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SAMPLE_COUNT: sample_count_q <= cfg_wdata_i[CNT_W-1:0];
        REG_DIVIDER:      ratio_q        <= cfg_wdata_i[RATIO_W-1:0];
        REG_EMPTY_MV:     empty_mv_q     <= cfg_wdata_i[MV_W-1:0];
        REG_FULL_MV:      full_mv_q      <= cfg_wdata_i[MV_W-1:0];
        default: ;
      endcase
    end
  end

  gauge_state_e state_q, state_d;

  logic        in_accept;
  acc_status_t acc_st;
  div_rsp_t    div_rsp;
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;

  // Working copies of the result being built.
  logic [SAMPLE_W-1:0] avg_q;
  logic [MV_W-1:0]     mv_q;
  logic [PCT_W-1:0]    pct_q;
  logic                err_q;

  // Output register.
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_avg_q;
  logic [MV_W-1:0]     out_mv_q;
  logic [PCT_W-1:0]    out_pct_q;
  logic                out_err_q;
  logic                out_free;
  logic                out_load;

  logic [PROD_W-1:0]  mv_prod;
  logic [DEN_W-1:0]   mv_den;
  logic [PPROD_W-1:0] pct_prod;
  logic               in_band;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  abg_accum u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .sample_i       (sample_i),
    .sample_ok_i    (sample_ok_i),
    .sample_count_i (sample_count_q),
    .status_o       (acc_st)
  );

  abg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .rsp_o   (div_rsp)
  );

  // Millivolts = mean * 3300 * 2^16 / (full scale * ratio). The 2^16 factor
  // is an appended zero field, so only the two narrow products are built.
  assign mv_prod  = PROD_W'(avg_q) * PROD_W'(MV_SCALE);
  assign mv_den   = DEN_W'(ratio_q) * DEN_W'(ADC_FULL_SCALE);
  assign pct_prod = PPROD_W'(mv_q - empty_mv_q) * PPROD_W'(PCT_SCALE);
  // Strictly between the two end points the percent is interpolated;
  // otherwise it is clamped, which also covers full not above empty.
  assign in_band  = (mv_q > empty_mv_q) && (mv_q < full_mv_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (!sample_ok_i) begin
            state_d = ST_EMIT;
          end else if (acc_st.close) begin
            state_d = ST_AVG_RUN;
          end
        end
      end
      ST_AVG_RUN:   if (div_rsp.done) state_d = ST_MV_START;
      ST_MV_START:  state_d = ST_MV_RUN;
      ST_MV_RUN:    if (div_rsp.done) state_d = ST_PCT_START;
      ST_PCT_START: state_d = in_band ? ST_PCT_RUN : ST_EMIT;
      ST_PCT_RUN:   if (div_rsp.done) state_d = ST_EMIT;
      ST_EMIT:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Handshake and divider operand selection for each step.
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    div_start  = 1'b0;
    div_num    = NUM_W'(acc_st.sum);
    div_den    = DEN_W'(acc_st.n);
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        div_start  = in_accept && acc_st.close;
      end
      ST_MV_START: begin
        div_start = 1'b1;
        div_num   = {mv_prod, {QUOT_W{1'b0}}};
        div_den   = mv_den;
      end
      ST_PCT_START: begin
        div_start = in_band;
        div_num   = NUM_W'(pct_prod);
        div_den   = DEN_W'(full_mv_q - empty_mv_q);
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept && !sample_ok_i) begin
          avg_q <= '0;
          mv_q  <= '0;
          pct_q <= '0;
          err_q <= 1'b1;
        end else if (in_accept && acc_st.close) begin
          err_q <= 1'b0;
        end
      end
      ST_AVG_RUN: begin
        if (div_rsp.done) begin
          // A group size lowered mid-group can push the mean past full scale.
          avg_q <= (div_rsp.quot > QUOT_W'(AVG_MAX)) ? AVG_MAX : div_rsp.quot[SAMPLE_W-1:0];
        end
      end
      ST_MV_RUN: begin
        if (div_rsp.done) begin
          mv_q <= div_rsp.quot;
        end
      end
      ST_PCT_START: begin
        pct_q <= (mv_q <= empty_mv_q) ? '0 : PCT_W'(PCT_SCALE);
      end
      ST_PCT_RUN: begin
        if (div_rsp.done) begin
          pct_q <= div_rsp.quot[PCT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_avg_q <= avg_q;
      out_mv_q  <= mv_q;
      out_pct_q <= pct_q;
      out_err_q <= err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign average_raw_o    = out_avg_q;
  assign supply_mv_o      = out_mv_q;
  assign charge_percent_o = out_pct_q;
  assign read_error_o     = out_err_q;

endmodule

/* rtl/abg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abg_checker: port-level checks of the battery gauge
// Watches the gauge's ports and flags words or timing that the gauge must
// never show.
// ----------------------------------------------------------------------------
module abg_checker import abg_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                sample_ok_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [SAMPLE_W-1:0] average_raw_o,
  input logic [MV_W-1:0]     supply_mv_o,
  input logic [PCT_W-1:0]    charge_percent_o,
  input logic                read_error_o
);

  // A stalled result word stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_raw_o) &&
      $stable(supply_mv_o) && $stable(charge_percent_o) && $stable(read_error_o))
    else $error("stalled result word changed");

  // An error word carries no measurement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_error_o |->
      average_raw_o == '0 && supply_mv_o == '0 && charge_percent_o == '0)
    else $error("error word with nonzero fields");

  // The percent never leaves its range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> charge_percent_o <= PCT_W'(PCT_SCALE))
    else $error("charge percent above full");

  // A failed sample always leads to an error word, so input is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !sample_ok_i |=> in_stall_o)
    else $error("input not held after a failed sample");

endmodule

bind adc_average_battery_gauge abg_checker u_abg_checker (.*);
